[rtl/core/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and types for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned DEF_MAX_BLOCKS    = 65536;
  localparam int unsigned DEF_MAP_WORD_BITS = 64;

  // fixed field widths
  localparam int unsigned IDX_W = 16;
  localparam int unsigned CNT_W = 17;

  localparam logic [CNT_W-1:0] RESET_TOTAL = 17'd65536;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_DIVQ     = 7'b0000100,
    ST_DIVR     = 7'b0001000,
    ST_MODIFY   = 7'b0010000,
    ST_SCAN     = 7'b0100000,
    ST_ALLOC_WR = 7'b1000000
  } state_t;

endpackage

[rtl/core/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over an occupancy bitmap held in one RAM.
// ----------------------------------------------------------------------------
// After reset the map RAM is cleared one word per cycle, busy until all
// DEPTH = ceil(MAX_BLOCKS / MAP_WORD_BITS) words (1024 by default) are written.
// Free / write / read pass DIVQ, DIVR and MODIFY, then strobe; busy until the strobe.
// Allocate: the single RAM read port scans one map word per cycle; a hit is set
// in ALLOC_WR, which strobes the result. Allocate with a zero count strobes
// in the next cycle. The receiver cannot stall; each result shows for one cycle.
module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic [15:0]              block_index,
  input  logic                     bit_value,
  input  logic                     cfg_we,
  input  logic [16:0]              cfg_wdata,
  output logic                     done,
  output logic [15:0]              result_index,
  output logic                     read_value,
  output logic                     status,
  output logic [16:0]              free_count
);

  localparam int unsigned IDX_W = bba_pkg::IDX_W;
  localparam int unsigned CNT_W = bba_pkg::CNT_W;
  localparam int unsigned WB    = MAP_WORD_BITS;
  localparam int unsigned DEPTH = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = $clog2(MAP_WORD_BITS);

  // word = idx / WB by multiply with rounded-up reciprocal, exact for 16-bit idx
  localparam int unsigned DIV_S = IDX_W + PW;
  localparam int unsigned DIV_R = ((1 << DIV_S) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned RW    = $clog2(DIV_R + 1);
  localparam int unsigned PRODW = IDX_W + RW;

  localparam logic [CNT_W-1:0] LIMIT_CAP =
    (MAX_BLOCKS >= (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] RESET_LIMIT =
    (bba_pkg::RESET_TOTAL > LIMIT_CAP) ? LIMIT_CAP : bba_pkg::RESET_TOTAL;
  localparam logic [CNT_W-1:0] WORD_STEP = CNT_W'(MAP_WORD_BITS);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

  bba_pkg::state_t  state;
  bba_pkg::action_t act_reg;

  logic [IDX_W-1:0] idx_reg;
  logic             val_reg;
  logic             inrange;
  logic [IDX_W-1:0] q_reg;
  logic [PW-1:0]    pos_reg;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] free_blocks;
  logic [AW-1:0]    clr_addr;

  // scan pipeline
  logic [AW-1:0]    iss_addr;
  logic [AW-1:0]    chk_addr;
  logic             chk_valid;
  logic [CNT_W-1:0] chk_base;
  logic [CNT_W-1:0] chk_rem;
  logic [WB-1:0]    hit_word;
  logic [PW-1:0]    hit_pos;
  logic [AW-1:0]    hit_addr;
  logic [CNT_W-1:0] hit_base;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WB-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [WB-1:0]    ram_rdata;

  logic [PRODW-1:0] prod;
  logic [WB-1:0]    pos_onehot;
  logic [WB-1:0]    hit_onehot;
  logic [WB-1:0]    cand;
  logic             scan_found;
  logic [PW-1:0]    scan_pos;
  logic             scan_last;
  logic [CNT_W-1:0] cfg_eff;

  bba_ram #(
    .WIDTH(WB),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy       = (state != bba_pkg::ST_IDLE);
  assign free_count = free_blocks;
  assign cfg_eff    = (cfg_wdata > LIMIT_CAP) ? LIMIT_CAP : cfg_wdata;
  assign prod       = PRODW'(idx_reg) * PRODW'(DIV_R);
  assign pos_onehot = WB'(1) << pos_reg;
  assign hit_onehot = WB'(1) << hit_pos;

  // clear bits of the returning word that lie below the limit
  always_comb begin
    for (int p = 0; p < WB; p++) begin
      cand[p] = !ram_rdata[p] && (CNT_W'(p) < chk_rem);
    end
  end

  // lowest candidate wins
  always_comb begin
    scan_found = 1'b0;
    scan_pos   = '0;
    for (int p = WB - 1; p >= 0; p--) begin
      if (cand[p]) begin
        scan_found = 1'b1;
        scan_pos   = PW'(p);
      end
    end
  end

  assign scan_last = (chk_rem <= WORD_STEP);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      bba_pkg::ST_DIVR: begin
        ram_raddr = AW'(q_reg);
      end
      bba_pkg::ST_MODIFY: begin
        ram_we    = inrange && (act_reg != bba_pkg::ACT_READ);
        ram_waddr = AW'(q_reg);
        ram_wdata = (ram_rdata & ~pos_onehot) |
                    ((act_reg == bba_pkg::ACT_WRITE && val_reg) ? pos_onehot : '0);
      end
      bba_pkg::ST_SCAN: begin
        ram_raddr = iss_addr;
      end
      bba_pkg::ST_ALLOC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit_addr;
        ram_wdata = hit_word | hit_onehot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bba_pkg::ST_CLEAR;
      clr_addr    <= '0;
      limit       <= RESET_LIMIT;
      free_blocks <= RESET_LIMIT;
      done        <= 1'b0;
      chk_valid   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        bba_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= bba_pkg::ST_IDLE;
          end
        end
        bba_pkg::ST_IDLE: begin
          if (start) begin
            act_reg <= bba_pkg::action_t'(action);
            idx_reg <= block_index;
            val_reg <= bit_value;
            inrange <= (CNT_W'(block_index) < limit);
            if (bba_pkg::action_t'(action) == bba_pkg::ACT_ALLOC) begin
              if (free_blocks == '0) begin
                done         <= 1'b1;
                result_index <= '0;
                read_value   <= 1'b0;
                status       <= 1'b1;
              end else begin
                state     <= bba_pkg::ST_SCAN;
                iss_addr  <= '0;
                chk_addr  <= '0;
                chk_valid <= 1'b0;
                chk_base  <= '0;
                chk_rem   <= limit;
              end
            end else begin
              state <= bba_pkg::ST_DIVQ;
            end
          end
        end
        bba_pkg::ST_DIVQ: begin
          q_reg <= IDX_W'(prod >> DIV_S);
          state <= bba_pkg::ST_DIVR;
        end
        bba_pkg::ST_DIVR: begin
          pos_reg <= PW'(idx_reg - IDX_W'(q_reg * MAP_WORD_BITS));
          state   <= bba_pkg::ST_MODIFY;
        end
        bba_pkg::ST_MODIFY: begin
          done         <= 1'b1;
          result_index <= idx_reg;
          status       <= 1'b0;
          read_value   <= (act_reg == bba_pkg::ACT_READ) && inrange && ram_rdata[pos_reg];
          if (act_reg == bba_pkg::ACT_FREE && inrange && free_blocks < limit) begin
            free_blocks <= free_blocks + CNT_W'(1);
          end
          state <= bba_pkg::ST_IDLE;
        end
        bba_pkg::ST_SCAN: begin
          iss_addr  <= iss_addr + AW'(1);
          chk_valid <= 1'b1;
          if (chk_valid) begin
            if (scan_found) begin
              hit_word <= ram_rdata;
              hit_pos  <= scan_pos;
              hit_addr <= chk_addr;
              hit_base <= chk_base;
              state    <= bba_pkg::ST_ALLOC_WR;
            end else if (scan_last) begin
              done         <= 1'b1;
              result_index <= '0;
              read_value   <= 1'b0;
              status       <= 1'b1;
              state        <= bba_pkg::ST_IDLE;
            end else begin
              chk_addr <= chk_addr + AW'(1);
              chk_base <= chk_base + WORD_STEP;
              chk_rem  <= chk_rem - WORD_STEP;
            end
          end
        end
        bba_pkg::ST_ALLOC_WR: begin
          done         <= 1'b1;
          result_index <= IDX_W'(hit_base + CNT_W'(hit_pos));
          read_value   <= 1'b0;
          status       <= 1'b0;
          free_blocks  <= free_blocks - CNT_W'(1);
          state        <= bba_pkg::ST_IDLE;
        end
        default: begin
          state <= bba_pkg::ST_IDLE;
        end
      endcase
      // register write reloads the limit and the free count
      if (cfg_we) begin
        limit       <= cfg_eff;
        free_blocks <= cfg_eff;
      end
    end
  end

  a_free_le_limit: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= limit)
    else $error("free count above managed total");

  a_no_word_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::ST_CLEAR |-> !done)
    else $error("result strobe during map clear");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::ST_SCAN |-> !ram_we)
    else $error("map write during scan");

  a_hit_bit_clear: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::ST_ALLOC_WR |-> !hit_word[hit_pos])
    else $error("allocating a bit that is already set");

endmodule

[rtl/core/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
